// File: hdl/hpd_pkg.sv
// Shared types, sizes and codes for the Huffman pair-list decoder.
`default_nettype none
package hpd_pkg;

   // Number of byte symbols the tree covers (2 to 256).
   localparam int SYMBOLS = 256;

   // Field widths fixed by the word formats.
   localparam int KIND_W   = 2;
   localparam int SLOT_W   = 8;
   localparam int SYM_W    = 8;
   localparam int STATUS_W = 3;
   localparam int BIT_W    = 3;

   // Node ids: leaves are the symbol value, inner node k is INNER_BASE + k.
   localparam int NODE_W     = 9;
   localparam int INNER_BASE = 256;

   // Storage sizes that follow from the symbol count.
   localparam int SLOT_DEPTH    = SYMBOLS;
   localparam int SLOT_AW       = $clog2(SYMBOLS);
   localparam int SLOT_ENTRY_W  = NODE_W + 1;
   localparam int CHILD_DEPTH   = SYMBOLS - 1;
   localparam int CHILD_AW      = (CHILD_DEPTH > 1) ? $clog2(CHILD_DEPTH) : 1;
   localparam int CHILD_ENTRY_W = 2 * NODE_W;
   localparam int MERGE_W       = $clog2(SYMBOLS);

   localparam logic [MERGE_W-1:0]  FULL_COUNT = MERGE_W'(SYMBOLS - 1);
   localparam logic [CHILD_AW-1:0] ROOT_IDX   = CHILD_AW'(SYMBOLS - 2);
   localparam logic [SLOT_W:0]     SLOT_LIMIT = (SLOT_W + 1)'(SYMBOLS);
   localparam logic [NODE_W-1:0]   INNER_ID   = NODE_W'(INNER_BASE);
   localparam logic [BIT_W-1:0]    TOP_BIT    = BIT_W'(SYM_W - 1);

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Input word kinds.
   localparam logic [KIND_W-1:0] KIND_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAIR  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CODE  = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_PAIR   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_MANY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_ROOT    = 3'd4;

   // Operation decided by the front for each accepted word.
   typedef enum logic [2:0] {
      OP_START,
      OP_PAIR,
      OP_PAIR_BAD,
      OP_CODE,
      OP_OTHER
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [SLOT_W-1:0]  first_slot;
      logic [SLOT_W-1:0]  second_slot;
      logic [SYM_W-1:0]   code_byte;
   } cmd_type;

endpackage
`default_nettype wire

// File: hdl/hpd_req_if.sv
// Request channel: one input word with valid/ready handshake.
`default_nettype none
interface hpd_req_if;
   logic                        valid;
   logic                        ready;
   logic [hpd_pkg::KIND_W-1:0]  kind;
   logic [hpd_pkg::SLOT_W-1:0]  first_slot;
   logic [hpd_pkg::SLOT_W-1:0]  second_slot;
   logic [hpd_pkg::SYM_W-1:0]   code_byte;

   modport source (output valid, kind, first_slot, second_slot, code_byte, input ready);
   modport sink   (input valid, kind, first_slot, second_slot, code_byte, output ready);
endinterface
`default_nettype wire

// File: hdl/hpd_rsp_if.sv
// Response channel: one result word with valid/ready handshake.
`default_nettype none
interface hpd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hpd_pkg::SYM_W-1:0]     symbol;
   logic                          symbol_valid;
   logic                          last;
   logic [hpd_pkg::STATUS_W-1:0]  status;

   modport source (output valid, symbol, symbol_valid, last, status, input ready);
   modport sink   (input valid, symbol, symbol_valid, last, status, output ready);
endinterface
`default_nettype wire

// File: hdl/hpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hpd_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: hdl/hpd_front.sv
// Front end: accepts request words and classifies them into commands.
`default_nettype none
module hpd_front (
   hpd_req_if.sink             req_ch,
   output logic                push_valid,
   input  logic                push_ready,
   output hpd_pkg::cmd_type    push_cmd
);

   logic pair_bad;

   // A pair is rejected outright if it names one slot twice or a slot past the symbol range.
   assign pair_bad = (req_ch.first_slot == req_ch.second_slot)
                  || ({1'b0, req_ch.first_slot}  >= hpd_pkg::SLOT_LIMIT)
                  || ({1'b0, req_ch.second_slot} >= hpd_pkg::SLOT_LIMIT);

   always_comb begin
      push_cmd.first_slot  = req_ch.first_slot;
      push_cmd.second_slot = req_ch.second_slot;
      push_cmd.code_byte   = req_ch.code_byte;
      case (req_ch.kind)
         hpd_pkg::KIND_START: begin
            push_cmd.op = hpd_pkg::OP_START;
         end
         hpd_pkg::KIND_PAIR: begin
            push_cmd.op = pair_bad ? hpd_pkg::OP_PAIR_BAD : hpd_pkg::OP_PAIR;
         end
         hpd_pkg::KIND_CODE: begin
            push_cmd.op = hpd_pkg::OP_CODE;
         end
         default: begin
            push_cmd.op = hpd_pkg::OP_OTHER;
         end
      endcase
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

endmodule
`default_nettype wire

// File: hdl/hpd_queue.sv
// Short command queue that decouples the front end from the back end.
`default_nettype none
module hpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  hpd_pkg::cmd_type    push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output hpd_pkg::cmd_type    pop_cmd
);

   hpd_pkg::cmd_type                 entry_ff [hpd_pkg::QUEUE_DEPTH];
   logic [hpd_pkg::QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [hpd_pkg::QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [hpd_pkg::QUEUE_CW-1:0]     count_ff, count_in;
   logic                             do_push, do_pop;

   assign push_ready = (count_ff != hpd_pkg::QUEUE_CW'(hpd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == hpd_pkg::QUEUE_AW'(hpd_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == hpd_pkg::QUEUE_AW'(hpd_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// File: hdl/hpd_back.sv
// Back end: builds the tree from merge pairs and walks code bytes through it.
`default_nettype none
module hpd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  hpd_pkg::cmd_type    pop_cmd,
   hpd_rsp_if.source           rsp_ch
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_REPLY  = 7'b0000010,
      S_PAIR_A = 7'b0000100,
      S_PAIR_B = 7'b0001000,
      S_PAIR_W = 7'b0010000,
      S_WALK   = 7'b0100000,
      S_FINISH = 7'b1000000
   } back_state_type;

   back_state_type                        state_ff, state_in;
   logic [hpd_pkg::SLOT_AW-1:0]           a_ff, a_in;
   logic [hpd_pkg::SLOT_AW-1:0]           b_ff, b_in;
   logic [hpd_pkg::SYM_W-1:0]             byte_ff, byte_in;
   logic [hpd_pkg::BIT_W-1:0]             bit_ff, bit_in;
   logic [hpd_pkg::STATUS_W-1:0]          status_ff, status_in;
   logic [hpd_pkg::MERGE_W-1:0]           merge_ff, merge_in;
   logic                                  slot0_valid_ff, slot0_valid_in;
   logic [hpd_pkg::CHILD_AW-1:0]          walk_ff, walk_in;
   logic                                  pend_valid_ff, pend_valid_in;
   logic [hpd_pkg::SYM_W-1:0]             pend_sym_ff, pend_sym_in;
   logic [hpd_pkg::SLOT_ENTRY_W-1:0]      entry_a_ff, entry_a_in;
   logic [hpd_pkg::SLOT_DEPTH-1:0]        written_ff, written_in;

   logic                                  out_valid_ff, out_valid_in;
   logic [hpd_pkg::SYM_W-1:0]             out_sym_ff, out_sym_in;
   logic                                  out_symv_ff, out_symv_in;
   logic                                  out_last_ff, out_last_in;
   logic [hpd_pkg::STATUS_W-1:0]          out_status_ff, out_status_in;
   logic                                  out_load, out_free;

   logic                                  slot_we;
   logic [hpd_pkg::SLOT_AW-1:0]           slot_waddr, slot_raddr, slot_rd_addr;
   logic [hpd_pkg::SLOT_ENTRY_W-1:0]      slot_wdata, slot_rdata, slot_entry;

   logic                                  child_we;
   logic [hpd_pkg::CHILD_AW-1:0]          child_waddr, child_raddr;
   logic [hpd_pkg::CHILD_ENTRY_W-1:0]     child_wdata, child_rdata;

   logic [hpd_pkg::NODE_W-1:0]            next_id, next_off;
   logic [hpd_pkg::CHILD_AW-1:0]          next_idx, walk_new;
   logic                                  next_leaf, step_ok;

   hpd_ram #(
      .WIDTH (hpd_pkg::SLOT_ENTRY_W),
      .DEPTH (hpd_pkg::SLOT_DEPTH)
   ) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   hpd_ram #(
      .WIDTH (hpd_pkg::CHILD_ENTRY_W),
      .DEPTH (hpd_pkg::CHILD_DEPTH)
   ) u_child_ram (
      .clock (clock),
      .we    (child_we),
      .waddr (child_waddr),
      .wdata (child_wdata),
      .raddr (child_raddr),
      .rdata (child_rdata)
   );

   // A slot not written since the last start still holds its own leaf.
   assign slot_rd_addr = (state_ff == S_PAIR_B) ? b_ff : a_ff;
   assign slot_entry   = written_ff[slot_rd_addr] ? slot_rdata
                       : {1'b1, hpd_pkg::NODE_W'(slot_rd_addr)};

   // One walk step: pick the child for the current code bit.
   assign next_id   = byte_ff[bit_ff] ? child_rdata[hpd_pkg::NODE_W-1:0]
                                      : child_rdata[hpd_pkg::CHILD_ENTRY_W-1:hpd_pkg::NODE_W];
   assign next_leaf = (next_id < hpd_pkg::INNER_ID);
   assign next_off  = next_id - hpd_pkg::INNER_ID;
   assign next_idx  = next_off[hpd_pkg::CHILD_AW-1:0];
   assign walk_new  = next_leaf ? hpd_pkg::ROOT_IDX : next_idx;

   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign step_ok   = !next_leaf || !pend_valid_ff || out_free;
   assign pop_ready = (state_ff == S_IDLE);

   // The child read address holds still unless the walk advances, so a stalled
   // step keeps its node entry on the read port.
   assign child_raddr = ((state_ff == S_WALK) && step_ok) ? walk_new : walk_ff;
   assign child_waddr = merge_ff[hpd_pkg::CHILD_AW-1:0];
   assign child_wdata = {entry_a_ff[hpd_pkg::NODE_W-1:0], slot_entry[hpd_pkg::NODE_W-1:0]};

   always_comb begin
      state_in       = state_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      byte_in        = byte_ff;
      bit_in         = bit_ff;
      status_in      = status_ff;
      merge_in       = merge_ff;
      slot0_valid_in = slot0_valid_ff;
      walk_in        = walk_ff;
      pend_valid_in  = pend_valid_ff;
      pend_sym_in    = pend_sym_ff;
      entry_a_in     = entry_a_ff;
      written_in     = written_ff;
      slot_we        = 1'b0;
      slot_waddr     = a_ff;
      slot_wdata     = '0;
      slot_raddr     = a_ff;
      child_we       = 1'b0;
      out_load       = 1'b0;
      out_sym_in     = out_sym_ff;
      out_symv_in    = out_symv_ff;
      out_last_in    = out_last_ff;
      out_status_in  = out_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               a_in       = pop_cmd.first_slot[hpd_pkg::SLOT_AW-1:0];
               b_in       = pop_cmd.second_slot[hpd_pkg::SLOT_AW-1:0];
               slot_raddr = pop_cmd.first_slot[hpd_pkg::SLOT_AW-1:0];
               status_in  = hpd_pkg::ST_OK;
               state_in   = S_REPLY;
               case (pop_cmd.op)
                  hpd_pkg::OP_START: begin
                     written_in     = '0;
                     merge_in       = '0;
                     slot0_valid_in = 1'b1;
                     walk_in        = hpd_pkg::ROOT_IDX;
                  end
                  hpd_pkg::OP_PAIR: begin
                     if (merge_ff >= hpd_pkg::FULL_COUNT) begin
                        status_in = hpd_pkg::ST_TOO_MANY;
                     end else begin
                        state_in = S_PAIR_A;
                     end
                  end
                  hpd_pkg::OP_PAIR_BAD: begin
                     status_in = (merge_ff >= hpd_pkg::FULL_COUNT) ? hpd_pkg::ST_TOO_MANY
                                                                   : hpd_pkg::ST_BAD_PAIR;
                  end
                  hpd_pkg::OP_CODE: begin
                     if (merge_ff < hpd_pkg::FULL_COUNT) begin
                        status_in = hpd_pkg::ST_INCOMPLETE;
                     end else if (!slot0_valid_ff) begin
                        status_in = hpd_pkg::ST_NO_ROOT;
                     end else begin
                        byte_in       = pop_cmd.code_byte;
                        bit_in        = hpd_pkg::TOP_BIT;
                        pend_valid_in = 1'b0;
                        state_in      = S_WALK;
                     end
                  end
                  default: begin
                     status_in = hpd_pkg::ST_OK;
                  end
               endcase
            end
         end

         S_PAIR_A: begin
            entry_a_in = slot_entry;
            slot_raddr = b_ff;
            state_in   = S_PAIR_B;
         end

         S_PAIR_B: begin
            if (entry_a_ff[hpd_pkg::NODE_W] && slot_entry[hpd_pkg::NODE_W]) begin
               child_we       = 1'b1;
               slot_we        = 1'b1;
               slot_waddr     = a_ff;
               slot_wdata     = {1'b1, hpd_pkg::INNER_ID + hpd_pkg::NODE_W'(merge_ff)};
               written_in[a_ff] = 1'b1;
               if (a_ff == '0) begin
                  slot0_valid_in = 1'b1;
               end
               state_in = S_PAIR_W;
            end else begin
               status_in = hpd_pkg::ST_BAD_PAIR;
               state_in  = S_REPLY;
            end
         end

         S_PAIR_W: begin
            slot_we          = 1'b1;
            slot_waddr       = b_ff;
            slot_wdata       = '0;
            written_in[b_ff] = 1'b1;
            if (b_ff == '0) begin
               slot0_valid_in = 1'b0;
            end
            merge_in  = merge_ff + 1'b1;
            walk_in   = hpd_pkg::ROOT_IDX;
            status_in = hpd_pkg::ST_OK;
            state_in  = S_REPLY;
         end

         S_WALK: begin
            if (step_ok) begin
               walk_in = walk_new;
               if (next_leaf) begin
                  // The symbol found earlier is now known not to be the last one.
                  if (pend_valid_ff) begin
                     out_load      = 1'b1;
                     out_sym_in    = pend_sym_ff;
                     out_symv_in   = 1'b1;
                     out_last_in   = 1'b0;
                     out_status_in = hpd_pkg::ST_OK;
                  end
                  pend_valid_in = 1'b1;
                  pend_sym_in   = next_id[hpd_pkg::SYM_W-1:0];
               end
               if (bit_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  bit_in = bit_ff - 1'b1;
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_sym_in    = pend_valid_ff ? pend_sym_ff : '0;
               out_symv_in   = pend_valid_ff;
               out_last_in   = 1'b1;
               out_status_in = hpd_pkg::ST_OK;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         S_REPLY: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_sym_in    = '0;
               out_symv_in   = 1'b0;
               out_last_in   = 1'b1;
               out_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         merge_ff       <= '0;
         slot0_valid_ff <= 1'b1;
         walk_ff        <= hpd_pkg::ROOT_IDX;
         pend_valid_ff  <= 1'b0;
         written_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         merge_ff       <= merge_in;
         slot0_valid_ff <= slot0_valid_in;
         walk_ff        <= walk_in;
         pend_valid_ff  <= pend_valid_in;
         written_ff     <= written_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      byte_ff       <= byte_in;
      bit_ff        <= bit_in;
      status_ff     <= status_in;
      pend_sym_ff   <= pend_sym_in;
      entry_a_ff    <= entry_a_in;
      out_sym_ff    <= out_sym_in;
      out_symv_ff   <= out_symv_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.symbol       = out_sym_ff;
   assign rsp_ch.symbol_valid = out_symv_ff;
   assign rsp_ch.last         = out_last_ff;
   assign rsp_ch.status       = out_status_ff;

endmodule
`default_nettype wire

// File: hdl/huffman_pair_list_decoder_core.sv
// Top level of the Huffman pair-list decoder: front end, command queue and back end.
`default_nettype none
// The decoder takes three kinds of request words: a start word that resets every slot to
// its own leaf, merge-pair words that build the tree one inner node at a time, and code
// bytes that are walked most significant bit first from the root. Start, pair and
// unrecognized words each give one response word with last set and a status; a code byte
// gives one response word per decoded symbol, last on the final one, or a single word with
// no symbol if none completed (a walk cut mid-byte resumes on the next code byte). Pairs
// that reuse a slot, name an empty or out-of-range slot, or arrive after the tree is full
// are flagged and ignored, as are code bytes sent before the tree is complete or while slot
// zero is empty. Requests enter a two-word command queue, so the request side keeps taking
// words while the back end works or the response side stalls, until the queue is full. In
// the back end a start, unknown, refused code or front-flagged word goes straight to the
// response, a pair refused for an empty slot first reads both slots, an accepted pair makes
// two reads and two writes on the slot memory, then the response, and a code byte makes the
// eight dependent reads of the child-node memory, one per code bit, between entering the
// walk and closing it. No clearing pass is needed after reset: per-slot written flags make
// unwritten slots read as their own leaf at once.
module huffman_pair_list_decoder_core (
   input  logic         clock,
   input  logic         reset,
   hpd_req_if.sink      req_ch,
   hpd_rsp_if.source    rsp_ch
);

   // Classified commands from the front end into the queue.
   logic                push_valid;
   logic                push_ready;
   hpd_pkg::cmd_type    push_cmd;

   // Commands from the queue into the back end.
   logic                pop_valid;
   logic                pop_ready;
   hpd_pkg::cmd_type    pop_cmd;

   // The front end sorts each word by kind and settles the pair checks that need no state.
   hpd_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // The queue lets the request side run ahead of the tree walk.
   hpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // The back end owns the slot and child memories and the response register.
   hpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire
